### rtl/core/mcid_pkg.sv
// mcid_pkg: shared widths, reset values, register codes and stage types
// for the multi-channel impact detector; no dependencies
`timescale 1ns / 1ps

package mcid_pkg;

    localparam int MAX_CH  = 9;
    localparam int CH_W    = 4;
    localparam int SMP_W   = 12;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 16;
    localparam int THR_W   = 12;
    localparam int HOLD_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 1;

    localparam logic [THR_W-1:0]  THR_RESET  = 12'd1000;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd120;

    localparam logic [CIDX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_HOLDOFF   = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic [SMP_W-1:0]  peak;
        logic [CH_W-1:0]   ch;
        logic              thr_ok;
    } t_s1;

endpackage

### rtl/core/mcid_scan_if.sv
// mcid_scan_if: input channel carrying one scan beat (timestamp and samples)
// depends on nothing
`timescale 1ns / 1ps

interface mcid_scan_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic [11:0] sample_0;
    logic [11:0] sample_1;
    logic [11:0] sample_2;
    logic [11:0] sample_3;
    logic [11:0] sample_4;
    logic [11:0] sample_5;
    logic [11:0] sample_6;
    logic [11:0] sample_7;
    logic [11:0] sample_8;

    modport source (
        output valid, now_ms, sample_0, sample_1, sample_2, sample_3, sample_4,
               sample_5, sample_6, sample_7, sample_8,
        input  ready
    );
    modport sink (
        input  valid, now_ms, sample_0, sample_1, sample_2, sample_3, sample_4,
               sample_5, sample_6, sample_7, sample_8,
        output ready
    );
endinterface

### rtl/core/mcid_hit_if.sv
// mcid_hit_if: output channel carrying one hit event beat
// depends on nothing
`timescale 1ns / 1ps

interface mcid_hit_if;
    logic        valid;
    logic        ready;
    logic [31:0] hit_time;
    logic [3:0]  hit_channel;
    logic [11:0] hit_peak;
    logic [15:0] count_0;
    logic [15:0] count_1;
    logic [15:0] count_2;
    logic [15:0] count_3;
    logic [15:0] count_4;
    logic [15:0] count_5;
    logic [15:0] count_6;
    logic [15:0] count_7;
    logic [15:0] count_8;

    modport source (
        output valid, hit_time, hit_channel, hit_peak, count_0, count_1, count_2,
               count_3, count_4, count_5, count_6, count_7, count_8,
        input  ready
    );
    modport sink (
        input  valid, hit_time, hit_channel, hit_peak, count_0, count_1, count_2,
               count_3, count_4, count_5, count_6, count_7, count_8,
        output ready
    );
endinterface

### rtl/core/mcid_peak.sv
// mcid_peak: registered max tree over the scan samples, lowest channel wins ties,
// plus the threshold test; depends on mcid_pkg
`timescale 1ns / 1ps

module mcid_peak #(
    parameter int NUM_CHANNELS = 9,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic [mcid_pkg::TIME_W-1:0]   i_now,
    input  logic [mcid_pkg::SMP_W-1:0]    i_sample [mcid_pkg::MAX_CH],
    input  logic [mcid_pkg::THR_W-1:0]    i_thr,
    output mcid_pkg::t_s1                 o_s1
);

    localparam int SW  = (SAMPLE_BITS < mcid_pkg::SMP_W) ? SAMPLE_BITS : mcid_pkg::SMP_W;
    localparam int LVL = $clog2(NUM_CHANNELS);
    localparam int NP  = 1 << LVL;

    logic [SW-1:0]             lvl_val [LVL+1][NP];
    logic [mcid_pkg::CH_W-1:0] lvl_ch  [LVL+1][NP];
    mcid_pkg::t_s1             n_s1;
    mcid_pkg::t_s1             r_s1;

    // leaves, padding lanes read as zero on a high index so they never win
    for (genvar n = 0; n < NP; n++) begin : g_leaf
        if (n < NUM_CHANNELS) begin : g_used
            assign lvl_val[0][n] = i_sample[n][SW-1:0];
        end else begin : g_pad
            assign lvl_val[0][n] = '0;
        end
        assign lvl_ch[0][n] = mcid_pkg::CH_W'(n);
    end

    for (genvar l = 0; l < LVL; l++) begin : g_lvl
        for (genvar n = 0; n < (NP >> (l + 1)); n++) begin : g_node
            logic take_hi;
            assign take_hi = lvl_val[l][2*n+1] > lvl_val[l][2*n];
            assign lvl_val[l+1][n] = take_hi ? lvl_val[l][2*n+1] : lvl_val[l][2*n];
            assign lvl_ch[l+1][n]  = take_hi ? lvl_ch[l][2*n+1]  : lvl_ch[l][2*n];
        end
        for (genvar n = (NP >> (l + 1)); n < NP; n++) begin : g_unused
            assign lvl_val[l+1][n] = '0;
            assign lvl_ch[l+1][n]  = '0;
        end
    end

    always_comb begin
        n_s1.now    = i_now;
        n_s1.peak   = mcid_pkg::SMP_W'(lvl_val[LVL][0]);
        n_s1.ch     = lvl_ch[LVL][0];
        n_s1.thr_ok = n_s1.peak >= i_thr;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

### rtl/core/mcid_lane.sv
// mcid_lane: one channel's hit counter and last hit time, with its holdoff test
// depends on mcid_pkg
`timescale 1ns / 1ps

module mcid_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mcid_pkg::TIME_W-1:0]   i_now,
    input  logic [mcid_pkg::HOLD_W-1:0]   i_holdoff,
    input  logic                          i_hit,
    output logic                          o_open,
    output logic [mcid_pkg::CNT_W-1:0]    o_count_next
);

    logic [mcid_pkg::CNT_W-1:0]  r_count;
    logic [mcid_pkg::CNT_W-1:0]  n_count;
    logic [mcid_pkg::TIME_W-1:0] r_last;
    logic [mcid_pkg::TIME_W-1:0] elapsed;

    // wraps modulo 2^32
    assign elapsed = i_now - r_last;
    assign o_open  = elapsed >= mcid_pkg::TIME_W'(i_holdoff);
    assign n_count = i_hit ? r_count + 1'b1 : r_count;
    assign o_count_next = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_last  <= '0;
        end else if (i_hit) begin
            r_count <= n_count;
            r_last  <= i_now;
        end
    end

endmodule

### rtl/core/multi_channel_impact_detector.sv
// multi_channel_impact_detector: top level, peak stage, channel lanes and the
// merging output register; depends on mcid_pkg, mcid_scan_if, mcid_hit_if,
// mcid_peak, mcid_lane
//
//   port     dir  beat                                     role
//   i_scan   in   now_ms, sample_0..sample_8               one scan per beat
//   o_hit    out  hit_time, hit_channel, hit_peak, counts  zero or one per scan
//   i_cfg_*  in   index, data (no handshake)               threshold, holdoff
//
// one scan per cycle unless o_hit stalls; hits leave from the output register
// stage one is the max tree, stage two the lane holdoff test and counter update
// synchronous active-low reset clears counters, last hit times and valid flags
// while a hit waits on o_hit stage one takes one more scan, then i_scan stalls
`timescale 1ns / 1ps

module multi_channel_impact_detector #(
    parameter int NUM_CHANNELS = 9,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mcid_scan_if.sink                       i_scan,
    mcid_hit_if.source                      o_hit,
    input  logic                            i_cfg_we,
    input  logic [mcid_pkg::CIDX_W-1:0]     i_cfg_idx,
    input  logic [mcid_pkg::CFG_W-1:0]      i_cfg_data
);

    logic [mcid_pkg::THR_W-1:0]  r_thr;
    logic [mcid_pkg::HOLD_W-1:0] r_holdoff;

    logic [mcid_pkg::SMP_W-1:0]  scan_smp [mcid_pkg::MAX_CH];
    logic                        accept;
    logic                        adv;
    logic                        r_s1_valid;
    mcid_pkg::t_s1               s1;

    logic [NUM_CHANNELS-1:0]     lane_sel;
    logic [NUM_CHANNELS-1:0]     lane_open;
    logic [NUM_CHANNELS-1:0]     lane_hit;
    logic [mcid_pkg::CNT_W-1:0]  lane_cnt [NUM_CHANNELS];
    logic                        hit;

    logic                        r_out_valid;
    logic [mcid_pkg::TIME_W-1:0] r_hit_time;
    logic [mcid_pkg::CH_W-1:0]   r_hit_ch;
    logic [mcid_pkg::SMP_W-1:0]  r_hit_peak;
    logic [mcid_pkg::CNT_W-1:0]  r_count [mcid_pkg::MAX_CH];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= mcid_pkg::THR_RESET;
            r_holdoff <= mcid_pkg::HOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mcid_pkg::CFG_THRESHOLD: r_thr     <= i_cfg_data[mcid_pkg::THR_W-1:0];
                mcid_pkg::CFG_HOLDOFF:   r_holdoff <= i_cfg_data[mcid_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    assign scan_smp[0] = i_scan.sample_0;
    assign scan_smp[1] = i_scan.sample_1;
    assign scan_smp[2] = i_scan.sample_2;
    assign scan_smp[3] = i_scan.sample_3;
    assign scan_smp[4] = i_scan.sample_4;
    assign scan_smp[5] = i_scan.sample_5;
    assign scan_smp[6] = i_scan.sample_6;
    assign scan_smp[7] = i_scan.sample_7;
    assign scan_smp[8] = i_scan.sample_8;

    // stage two drains when the output register is free or being taken
    assign adv          = !r_out_valid || o_hit.ready;
    assign i_scan.ready = !r_s1_valid || adv;
    assign accept       = i_scan.valid && i_scan.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    mcid_peak #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_peak (
        .i_clk    (i_clk),
        .i_load   (accept),
        .i_now    (i_scan.now_ms),
        .i_sample (scan_smp),
        .i_thr    (r_thr),
        .o_s1     (s1)
    );

    for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lane
        assign lane_sel[i] = s1.ch == mcid_pkg::CH_W'(i);
        assign lane_hit[i] = lane_sel[i] && hit;

        mcid_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_now        (s1.now),
            .i_holdoff    (r_holdoff),
            .i_hit        (lane_hit[i]),
            .o_open       (lane_open[i]),
            .o_count_next (lane_cnt[i])
        );
    end

    // merge: the peak channel's lane decides
    assign hit = r_s1_valid && adv && s1.thr_ok && |(lane_sel & lane_open);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit) begin
            r_hit_time <= s1.now;
            r_hit_ch   <= s1.ch;
            r_hit_peak <= s1.peak;
        end
    end

    for (genvar i = 0; i < mcid_pkg::MAX_CH; i++) begin : g_cnt
        if (i < NUM_CHANNELS) begin : g_used
            always_ff @(posedge i_clk) begin
                if (hit) begin
                    r_count[i] <= lane_cnt[i];
                end
            end
        end else begin : g_unused
            assign r_count[i] = '0;
        end
    end

    assign o_hit.valid       = r_out_valid;
    assign o_hit.hit_time    = r_hit_time;
    assign o_hit.hit_channel = r_hit_ch;
    assign o_hit.hit_peak    = r_hit_peak;
    assign o_hit.count_0     = r_count[0];
    assign o_hit.count_1     = r_count[1];
    assign o_hit.count_2     = r_count[2];
    assign o_hit.count_3     = r_count[3];
    assign o_hit.count_4     = r_count[4];
    assign o_hit.count_5     = r_count[5];
    assign o_hit.count_6     = r_count[6];
    assign o_hit.count_7     = r_count[7];
    assign o_hit.count_8     = r_count[8];

`ifndef SYNTHESIS
    a_one_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(lane_hit))
        else $error("more than one lane updated");

    a_hit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit |=> (o_hit.valid && o_hit.hit_time == $past(s1.now)
                 && o_hit.hit_channel == $past(s1.ch)))
        else $error("hit beat does not match its scan");

    a_peak_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit.valid |-> o_hit.hit_peak >= r_thr)
        else $error("hit beat below threshold");

    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> s1.ch < mcid_pkg::CH_W'(NUM_CHANNELS))
        else $error("peak channel out of range");
`endif

endmodule

### bench/multi_channel_impact_detector_tb.sv
// multi_channel_impact_detector_tb: self-checking bench for the impact detector, a directed
// table then random scans checked against a peak/holdoff predictor
// depends on mcid_pkg, mcid_scan_if, mcid_hit_if and multi_channel_impact_detector
`timescale 1ns / 1ps

module multi_channel_impact_detector_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 4;

    typedef logic [mcid_pkg::SMP_W-1:0] t_smp_arr [mcid_pkg::MAX_CH];
    typedef logic [mcid_pkg::CNT_W-1:0] t_cnt_arr [mcid_pkg::MAX_CH];

    typedef struct {
        logic [mcid_pkg::TIME_W-1:0] now;
        t_smp_arr                    smp;
    } t_scan;

    typedef struct {
        logic [mcid_pkg::TIME_W-1:0] stamp;
        logic [mcid_pkg::CH_W-1:0]   chan;
        logic [mcid_pkg::SMP_W-1:0]  peak;
        t_cnt_arr                    cnt;
    } t_hit;

    typedef struct {
        bit   typed;
        bit   exp_hit;
        t_hit exp;
    } t_scan_note;

    typedef enum {ROW_SCAN, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind                  kind;
        logic [mcid_pkg::CFG_W-1:0] thr_data;
        logic [mcid_pkg::CFG_W-1:0] hold_data;
        t_scan                      scan;
        t_scan_note                 note;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [mcid_pkg::CIDX_W-1:0] i_cfg_idx;
    logic [mcid_pkg::CFG_W-1:0]  i_cfg_data;

    mcid_scan_if scan_bus ();
    mcid_hit_if  hit_bus ();

    multi_channel_impact_detector #(
        .NUM_CHANNELS (mcid_pkg::MAX_CH),
        .SAMPLE_BITS  (mcid_pkg::SMP_W)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_scan     (scan_bus),
        .o_hit      (hit_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state
    logic [mcid_pkg::THR_W-1:0]  thr_reg;
    logic [mcid_pkg::HOLD_W-1:0] hold_reg;
    t_cnt_arr                    hit_cnt;
    logic [mcid_pkg::TIME_W-1:0] last_hit [mcid_pkg::MAX_CH];

    t_hit       pending_hits [$];
    t_scan_note scan_notes [$];
    t_row       dir_rows [$];

    t_cnt_arr   zero_cnt;
    t_scan_note plain_note;
    int         err_count;
    int         quiet_cycles;
    int         rx_hold;
    bit         idle_off;
    logic [mcid_pkg::TIME_W-1:0] walk_ms;

    t_scan      seen_scan;
    t_scan_note seen_note;
    t_hit       pred;
    t_hit       want;
    bit         pred_hit;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        err_count++;
        if (err_count <= 200)
            $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, exp_val);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch(what, got, exp_val);
    endtask

    function automatic bit predict_hit(input t_scan s, output t_hit h);
        logic [mcid_pkg::SMP_W-1:0]  peak;
        logic [mcid_pkg::CH_W-1:0]   ch;
        logic [mcid_pkg::TIME_W-1:0] elapsed;
        peak = '0;
        ch = '0;
        for (int i = 0; i < mcid_pkg::MAX_CH; i++) begin
            if (s.smp[i] > peak) begin
                peak = s.smp[i];
                ch = mcid_pkg::CH_W'(i);
            end
        end
        if (peak < thr_reg)
            return 1'b0;
        elapsed = s.now - last_hit[ch];
        if (elapsed < mcid_pkg::TIME_W'(hold_reg))
            return 1'b0;
        last_hit[ch] = s.now;
        hit_cnt[ch] = hit_cnt[ch] + 1'b1;
        h.stamp = s.now;
        h.chan = ch;
        h.peak = peak;
        h.cnt = hit_cnt;
        return 1'b1;
    endfunction

    function automatic t_hit mk_hit(input logic [mcid_pkg::TIME_W-1:0] t,
                                    input logic [mcid_pkg::CH_W-1:0] c,
                                    input logic [mcid_pkg::SMP_W-1:0] p, input t_cnt_arr n);
        t_hit h;
        h.stamp = t;
        h.chan = c;
        h.peak = p;
        h.cnt = n;
        return h;
    endfunction

    function automatic t_smp_arr one_smp(input logic [mcid_pkg::CH_W-1:0] ch,
                                         input logic [mcid_pkg::SMP_W-1:0] val);
        t_smp_arr a;
        a = '{default: '0};
        a[ch] = val;
        return a;
    endfunction

    function automatic void add_scan(input logic [mcid_pkg::TIME_W-1:0] now, input t_smp_arr smp,
                                     input bit typed, input bit exp_hit, input t_hit exp);
        t_row r;
        r.kind = ROW_SCAN;
        r.thr_data = '0;
        r.hold_data = '0;
        r.scan.now = now;
        r.scan.smp = smp;
        r.note.typed = typed;
        r.note.exp_hit = exp_hit;
        r.note.exp = exp;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_cfg(input logic [mcid_pkg::CFG_W-1:0] thr_data,
                                    input logic [mcid_pkg::CFG_W-1:0] hold_data);
        t_row r;
        r.kind = ROW_CFG;
        r.thr_data = thr_data;
        r.hold_data = hold_data;
        r.scan.now = '0;
        r.scan.smp = '{default: '0};
        r.note = plain_note;
        dir_rows.push_back(r);
    endfunction

    // scan and hit beats at the rising edge, plus the stall watchdog
    always @(posedge i_clk) begin
        if (hit_bus.valid && hit_bus.ready) begin
            if (pending_hits.size() == 0) begin
                report_mismatch("unexpected hit_time", hit_bus.hit_time, '0);
            end else begin
                want = pending_hits.pop_front();
                check_field("hit_time", hit_bus.hit_time, want.stamp);
                check_field("hit_channel", 32'(hit_bus.hit_channel), 32'(want.chan));
                check_field("hit_peak", 32'(hit_bus.hit_peak), 32'(want.peak));
                check_field("count_0", 32'(hit_bus.count_0), 32'(want.cnt[0]));
                check_field("count_1", 32'(hit_bus.count_1), 32'(want.cnt[1]));
                check_field("count_2", 32'(hit_bus.count_2), 32'(want.cnt[2]));
                check_field("count_3", 32'(hit_bus.count_3), 32'(want.cnt[3]));
                check_field("count_4", 32'(hit_bus.count_4), 32'(want.cnt[4]));
                check_field("count_5", 32'(hit_bus.count_5), 32'(want.cnt[5]));
                check_field("count_6", 32'(hit_bus.count_6), 32'(want.cnt[6]));
                check_field("count_7", 32'(hit_bus.count_7), 32'(want.cnt[7]));
                check_field("count_8", 32'(hit_bus.count_8), 32'(want.cnt[8]));
            end
        end
        if (scan_bus.valid && scan_bus.ready) begin
            seen_scan.now = scan_bus.now_ms;
            seen_scan.smp[0] = scan_bus.sample_0;
            seen_scan.smp[1] = scan_bus.sample_1;
            seen_scan.smp[2] = scan_bus.sample_2;
            seen_scan.smp[3] = scan_bus.sample_3;
            seen_scan.smp[4] = scan_bus.sample_4;
            seen_scan.smp[5] = scan_bus.sample_5;
            seen_scan.smp[6] = scan_bus.sample_6;
            seen_scan.smp[7] = scan_bus.sample_7;
            seen_scan.smp[8] = scan_bus.sample_8;
            seen_note = scan_notes.pop_front();
            pred_hit = predict_hit(seen_scan, pred);
            if (seen_note.typed) begin
                if (seen_note.exp_hit)
                    pending_hits.push_back(seen_note.exp);
            end else if (pred_hit) begin
                pending_hits.push_back(pred);
            end
        end
        if ((scan_bus.valid && scan_bus.ready) || (hit_bus.valid && hit_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // hit receiver
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            hit_bus.ready <= 1'b0;
        end else begin
            hit_bus.ready <= idle_off || ($urandom_range(0, 99) >= 13);
        end
    end

    task automatic send_scan(input t_scan s, input t_scan_note note);
        scan_notes.push_back(note);
        while (!idle_off && $urandom_range(0, 99) < 13) begin
            scan_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        scan_bus.valid    <= 1'b1;
        scan_bus.now_ms   <= s.now;
        scan_bus.sample_0 <= s.smp[0];
        scan_bus.sample_1 <= s.smp[1];
        scan_bus.sample_2 <= s.smp[2];
        scan_bus.sample_3 <= s.smp[3];
        scan_bus.sample_4 <= s.smp[4];
        scan_bus.sample_5 <= s.smp[5];
        scan_bus.sample_6 <= s.smp[6];
        scan_bus.sample_7 <= s.smp[7];
        scan_bus.sample_8 <= s.smp[8];
        @(posedge i_clk);
        while (!scan_bus.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_hits();
        scan_bus.valid <= 1'b0;
        while (pending_hits.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_regs(input logic [mcid_pkg::CFG_W-1:0] thr_data,
                              input logic [mcid_pkg::CFG_W-1:0] hold_data);
        drain_hits();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= mcid_pkg::CFG_THRESHOLD;
        i_cfg_data <= thr_data;
        @(negedge i_clk);
        i_cfg_idx  <= mcid_pkg::CFG_HOLDOFF;
        i_cfg_data <= hold_data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        thr_reg  = thr_data[mcid_pkg::THR_W-1:0];
        hold_reg = hold_data[mcid_pkg::HOLD_W-1:0];
    endtask

    task automatic make_random_scan(output t_scan s);
        int lo;
        logic [mcid_pkg::CH_W-1:0] a;
        logic [mcid_pkg::CH_W-1:0] b;
        logic [mcid_pkg::SMP_W-1:0] v;
        if ($urandom_range(0, 9) == 0)
            walk_ms = $urandom;
        else
            walk_ms = walk_ms + $urandom_range(0, int'(hold_reg) / 3 + 3);
        s.now = walk_ms;
        lo = (thr_reg > 8) ? int'(thr_reg) - 8 : 0;
        a = mcid_pkg::CH_W'($urandom_range(0, mcid_pkg::MAX_CH - 1));
        b = mcid_pkg::CH_W'($urandom_range(0, mcid_pkg::MAX_CH - 1));
        v = mcid_pkg::SMP_W'($urandom_range(lo, 4095));
        case ($urandom_range(0, 9))
            0: begin
                foreach (s.smp[i]) s.smp[i] = mcid_pkg::SMP_W'($urandom_range(0, 4095));
            end
            1: begin
                s.smp = '{default: '0};
            end
            2: begin
                foreach (s.smp[i])
                    s.smp[i] = mcid_pkg::SMP_W'($urandom_range(0, int'(thr_reg) / 2));
                s.smp[a] = v;
                s.smp[b] = v;
            end
            default: begin
                foreach (s.smp[i])
                    s.smp[i] = mcid_pkg::SMP_W'($urandom_range(0, int'(thr_reg) / 2));
                s.smp[a] = v;
            end
        endcase
    endtask

    task automatic run_random(input int n);
        t_scan s;
        for (int k = 0; k < n; k++) begin
            make_random_scan(s);
            send_scan(s, plain_note);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        scan_bus.valid = 1'b0;
        scan_bus.now_ms = '0;
        scan_bus.sample_0 = '0;
        scan_bus.sample_1 = '0;
        scan_bus.sample_2 = '0;
        scan_bus.sample_3 = '0;
        scan_bus.sample_4 = '0;
        scan_bus.sample_5 = '0;
        scan_bus.sample_6 = '0;
        scan_bus.sample_7 = '0;
        scan_bus.sample_8 = '0;
        hit_bus.ready = 1'b0;
        err_count = 0;
        quiet_cycles = 0;
        rx_hold = 0;
        idle_off = 1'b0;
        walk_ms = '0;
        zero_cnt = '{default: '0};
        plain_note.typed = 1'b0;
        plain_note.exp_hit = 1'b0;
        plain_note.exp = mk_hit('0, '0, '0, zero_cnt);
        thr_reg = mcid_pkg::THR_RESET;
        hold_reg = mcid_pkg::HOLD_RESET;
        hit_cnt = '{default: '0};
        foreach (last_hit[i]) last_hit[i] = '0;

        // reset values: threshold 1000, holdoff 120
        add_scan(0, one_smp(0, 0), 1, 0, plain_note.exp);
        add_scan(119, one_smp(0, 4095), 1, 0, plain_note.exp);
        add_scan(120, one_smp(0, 4095), 1, 1,
                 mk_hit(120, 0, 4095, '{1, 0, 0, 0, 0, 0, 0, 0, 0}));
        add_scan(200, one_smp(8, 4095), 1, 1,
                 mk_hit(200, 8, 4095, '{1, 0, 0, 0, 0, 0, 0, 0, 1}));
        add_scan(1000, '{default: 12'hFFF}, 1, 1,
                 mk_hit(1000, 0, 4095, '{2, 0, 0, 0, 0, 0, 0, 0, 1}));
        add_scan(1001, '{0, 0, 0, 3000, 0, 3000, 0, 0, 0}, 1, 1,
                 mk_hit(1001, 3, 3000, '{2, 0, 0, 1, 0, 0, 0, 0, 1}));
        add_scan(1100, one_smp(0, 4095), 1, 0, plain_note.exp);
        add_scan(5000, one_smp(2, 999), 1, 0, plain_note.exp);
        add_scan(5000, one_smp(2, 1000), 1, 1,
                 mk_hit(5000, 2, 1000, '{2, 0, 1, 1, 0, 0, 0, 0, 1}));
        add_scan(32'hFFFF_FFFF, '{0, 0, 0, 0, 12'hAAA, 0, 12'h555, 0, 0}, 1, 1,
                 mk_hit(32'hFFFF_FFFF, 4, 12'hAAA, '{2, 0, 1, 1, 1, 0, 0, 0, 1}));
        // holdoff measured across the timestamp wrap
        add_scan(32'h76, one_smp(4, 12'hFFF), 1, 0, plain_note.exp);
        add_scan(32'h77, one_smp(4, 12'hFFF), 1, 1,
                 mk_hit(32'h77, 4, 12'hFFF, '{2, 0, 1, 1, 2, 0, 0, 0, 1}));
        add_scan(7777, '{12, 340, 4000, 17, 2222, 4000, 9, 0, 1234}, 0, 0, plain_note.exp);
        add_cfg(16'h0000, 16'h0000);
        add_scan(32'h1234_5678, one_smp(0, 0), 1, 1,
                 mk_hit(32'h1234_5678, 0, 0, '{3, 0, 2, 1, 2, 0, 0, 0, 1}));
        add_scan(32'h1234_5678, one_smp(0, 0), 1, 1,
                 mk_hit(32'h1234_5678, 0, 0, '{4, 0, 2, 1, 2, 0, 0, 0, 1}));
        add_scan(32'h8000_0000, one_smp(7, 12'h800), 1, 1,
                 mk_hit(32'h8000_0000, 7, 12'h800, '{4, 0, 2, 1, 2, 0, 0, 1, 1}));
        add_cfg(16'hFFFF, 16'hFFFF);
        add_scan(32'h0010_0000, one_smp(1, 4094), 1, 0, plain_note.exp);
        add_scan(32'h0001_0000, one_smp(1, 4095), 1, 1,
                 mk_hit(32'h0001_0000, 1, 4095, '{4, 1, 2, 1, 2, 0, 0, 1, 1}));
        add_scan(32'h0001_FFFE, one_smp(1, 4095), 1, 0, plain_note.exp);
        add_scan(32'h0001_FFFF, one_smp(1, 4095), 1, 1,
                 mk_hit(32'h0001_FFFF, 1, 4095, '{4, 2, 2, 1, 2, 0, 0, 1, 1}));
        // upper data bits beyond the threshold width are dropped
        add_cfg(16'hA7D0, 16'hFFFF);
        add_scan(32'h0002_0000, '{0, 0, 0, 0, 0, 2000, 1999, 0, 0}, 1, 1,
                 mk_hit(32'h0002_0000, 5, 2000, '{4, 2, 2, 1, 2, 1, 0, 1, 1}));

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                write_regs(dir_rows[r].thr_data, dir_rows[r].hold_data);
            end else begin
                send_scan(dir_rows[r].scan, dir_rows[r].note);
            end
        end

        write_regs(16'd1000, 16'd120);
        run_random(70);

        // back-to-back hits against a stalled receiver
        write_regs(16'h0000, 16'h0000);
        idle_off = 1'b1;
        rx_hold = 100;
        run_random(70);
        idle_off = 1'b0;

        write_regs(16'hFFFF, 16'hFFFF);
        run_random(70);

        write_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 400)));
        run_random(35);
        drain_hits();
        run_random(35);

        write_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 2000)));
        run_random(70);

        write_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        run_random(70);

        write_regs(16'h0000, 16'h0000);
        idle_off = 1'b1;
        run_random(10);
        idle_off = 1'b0;

        drain_hits();
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/core/mcid_pkg.sv
rtl/core/mcid_scan_if.sv
rtl/core/mcid_hit_if.sv
rtl/core/mcid_peak.sv
rtl/core/mcid_lane.sv
rtl/core/multi_channel_impact_detector.sv
bench/multi_channel_impact_detector_tb.sv
